// File: rtl/tot_pkg.sv
package tot_pkg;

    localparam int CAPACITY   = 16;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int COORD_W    = 8;
    localparam int TILE_W     = 8;
    localparam int SIZE_W     = 6;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [COORD_W-1:0] DRAW_MASK = 8'd31;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRAW    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTORE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RELOAD  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_H    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_SHOWN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_W     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_H     = 3'd6;

    // Command broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic               start;
        logic               ins;
        logic               upd;
        logic               dlt;
        logic [COORD_W-1:0] key_col;
        logic [COORD_W-1:0] key_row;
        logic [TILE_W-1:0]  tile;
    } cell_cmd_t;

endpackage

// File: rtl/tot_intf.sv
interface tot_req_if;
    logic                         valid;
    logic                         ready;
    logic [tot_pkg::OP_W-1:0]     operation;
    logic [tot_pkg::COORD_W-1:0]  cell_x;
    logic [tot_pkg::COORD_W-1:0]  cell_y;
    logic [tot_pkg::TILE_W-1:0]   tile_value;

    modport source (output valid, operation, cell_x, cell_y, tile_value, input ready);
    modport sink   (input valid, operation, cell_x, cell_y, tile_value, output ready);
endinterface

interface tot_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         succeeded;
    logic [tot_pkg::KIND_W-1:0]   redraw_kind;
    logic [tot_pkg::COORD_W-1:0]  redraw_x;
    logic [tot_pkg::COORD_W-1:0]  redraw_y;
    logic [tot_pkg::SIZE_W-1:0]   redraw_width;
    logic [tot_pkg::SIZE_W-1:0]   redraw_height;
    logic [tot_pkg::TILE_W-1:0]   redraw_tile;

    modport source (output valid, succeeded, redraw_kind, redraw_x, redraw_y,
                    redraw_width, redraw_height, redraw_tile, input ready);
    modport sink   (input valid, succeeded, redraw_kind, redraw_x, redraw_y,
                    redraw_width, redraw_height, redraw_tile, output ready);
endinterface

interface tot_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tot_pkg::CFG_IDX_W-1:0]   index;
    logic [tot_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/tot_cell.sv
// One table slot. A search token walks the chain one cell per cycle; the
// cell that sees its own key under the token marks itself selected.
module tot_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tot_pkg::cell_cmd_t           cmd,
    input  logic                         token_in,
    input  logic                         live,
    input  logic                         ins_here,
    input  logic                         after_in,
    input  logic [tot_pkg::COORD_W-1:0]  nb_col,
    input  logic [tot_pkg::COORD_W-1:0]  nb_row,
    input  logic [tot_pkg::TILE_W-1:0]   nb_tile,
    output logic                         token_out,
    output logic                         after_out,
    output logic                         sel,
    output logic [tot_pkg::COORD_W-1:0]  col,
    output logic [tot_pkg::COORD_W-1:0]  row,
    output logic [tot_pkg::TILE_W-1:0]   tile
);

    logic                         token_reg;
    logic                         sel_reg;
    logic                         sel_next;
    logic [tot_pkg::COORD_W-1:0]  col_reg;
    logic [tot_pkg::COORD_W-1:0]  col_next;
    logic [tot_pkg::COORD_W-1:0]  row_reg;
    logic [tot_pkg::COORD_W-1:0]  row_next;
    logic [tot_pkg::TILE_W-1:0]   tile_reg;
    logic [tot_pkg::TILE_W-1:0]   tile_next;

    always_comb
    begin
        sel_next = sel_reg;
        if (cmd.start)
        begin
            sel_next = 1'b0;
        end
        else if (token_reg && live && col_reg == cmd.key_col && row_reg == cmd.key_row)
        begin
            sel_next = 1'b1;
        end
    end

    // A delete closes the gap: every cell at or past the hit takes the
    // entry of its right-hand neighbor.
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        tile_next = tile_reg;
        if (cmd.ins && ins_here)
        begin
            col_next  = cmd.key_col;
            row_next  = cmd.key_row;
            tile_next = cmd.tile;
        end
        else if (cmd.upd && sel_reg)
        begin
            tile_next = cmd.tile;
        end
        else if (cmd.dlt && after_out)
        begin
            col_next  = nb_col;
            row_next  = nb_row;
            tile_next = nb_tile;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            token_reg <= token_in;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        row_reg  <= row_next;
        tile_reg <= tile_next;
    end

    assign token_out = token_reg;
    assign after_out = after_in | sel_reg;
    assign sel       = sel_reg;
    assign col       = col_reg;
    assign row       = row_reg;
    assign tile      = tile_reg;

endmodule

// File: rtl/tile_override_table.sv
// Channel   Dir   Payload                                            Handshake
// -------   ---   ------------------------------------------------   ---------
// req       in    operation, cell_x, cell_y, tile_value              valid/ready
// rsp       out   succeeded, redraw_kind/x/y/width/height/tile       valid/ready
// cfg       in    index (register number), data                      valid/ready
//
// An insert, update or delete request runs a search and then a commit: the
// search token crosses the chain of CAPACITY cells one cell per cycle, then
// the commit writes the cells and the result register. A clear request
// skips the search and goes straight to the commit. One request is worked
// on at a time, so no new request is taken before the last one commits.
// The next request is accepted as soon as the commit is done, even while the
// result register still waits for rsp.ready; a commit waits for that register.
// Reset clears the entry count and all handshake state and sets the
// configuration registers to their defaults; the entry payload is left as
// it is, since only entries below the count are ever looked at.
module tile_override_table (
    input  logic   clk,
    input  logic   rst_n,
    tot_req_if.sink   req,
    tot_rsp_if.source rsp,
    tot_cfg_if.sink   cfg
);

    localparam int Cap  = tot_pkg::CAPACITY;
    localparam int CntW = tot_pkg::CNT_W;
    localparam int SumW = tot_pkg::COORD_W + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    // Control state.
    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [CntW-1:0]              count_reg;
    logic [CntW-1:0]              count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    // The request being worked on.
    logic [tot_pkg::OP_W-1:0]     op_reg;
    logic [tot_pkg::COORD_W-1:0]  key_col_reg;
    logic [tot_pkg::COORD_W-1:0]  key_row_reg;
    logic [tot_pkg::TILE_W-1:0]   tile_reg;

    // Configuration registers.
    logic [tot_pkg::COORD_W-1:0]  view_x_reg;
    logic [tot_pkg::COORD_W-1:0]  view_y_reg;
    logic [tot_pkg::SIZE_W-1:0]   view_w_reg;
    logic [tot_pkg::SIZE_W-1:0]   view_h_reg;
    logic                         map_shown_reg;
    logic [tot_pkg::COORD_W-1:0]  map_w_reg;
    logic [tot_pkg::COORD_W-1:0]  map_h_reg;

    // Result register.
    logic                         ok_reg;
    logic                         ok_next;
    logic [tot_pkg::KIND_W-1:0]   kind_reg;
    logic [tot_pkg::KIND_W-1:0]   kind_next;
    logic [tot_pkg::COORD_W-1:0]  rx_reg;
    logic [tot_pkg::COORD_W-1:0]  rx_next;
    logic [tot_pkg::COORD_W-1:0]  ry_reg;
    logic [tot_pkg::COORD_W-1:0]  ry_next;
    logic [tot_pkg::SIZE_W-1:0]   rw_reg;
    logic [tot_pkg::SIZE_W-1:0]   rw_next;
    logic [tot_pkg::SIZE_W-1:0]   rh_reg;
    logic [tot_pkg::SIZE_W-1:0]   rh_next;
    logic [tot_pkg::TILE_W-1:0]   rt_reg;
    logic [tot_pkg::TILE_W-1:0]   rt_next;

    // Chain wiring.
    tot_pkg::cell_cmd_t           cmd;
    logic [Cap:0]                 token;
    logic [Cap:0]                 after;
    logic [Cap-1:0]               sel;
    logic [tot_pkg::COORD_W-1:0]  cell_col  [Cap];
    logic [tot_pkg::COORD_W-1:0]  cell_row  [Cap];
    logic [tot_pkg::TILE_W-1:0]   cell_tile [Cap];

    logic                         accept;
    logic                         commit;
    logic                         found;
    logic                         visible;
    logic                         reload_on;
    logic [SumW-1:0]              view_x_end;
    logic [SumW-1:0]              view_y_end;
    logic [tot_pkg::COORD_W-1:0]  clip_w;
    logic [tot_pkg::COORD_W-1:0]  clip_h;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign commit = (state_reg == ST_COMMIT) && (!out_valid_reg || rsp.ready);
    assign found  = |sel;

    // ------------------------------------------------------------------
    // Config port. The user writes only while the table is idle; not enforced.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_x_reg    <= '0;
            view_y_reg    <= '0;
            view_w_reg    <= tot_pkg::SIZE_W'(21);
            view_h_reg    <= tot_pkg::SIZE_W'(19);
            map_shown_reg <= 1'b0;
            map_w_reg     <= '0;
            map_h_reg     <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                tot_pkg::CFG_VIEW_X:    view_x_reg    <= cfg.data;
                tot_pkg::CFG_VIEW_Y:    view_y_reg    <= cfg.data;
                tot_pkg::CFG_VIEW_W:    view_w_reg    <= cfg.data[tot_pkg::SIZE_W-1:0];
                tot_pkg::CFG_VIEW_H:    view_h_reg    <= cfg.data[tot_pkg::SIZE_W-1:0];
                tot_pkg::CFG_MAP_SHOWN: map_shown_reg <= cfg.data[0];
                tot_pkg::CFG_MAP_W:     map_w_reg     <= cfg.data;
                tot_pkg::CFG_MAP_H:     map_h_reg     <= cfg.data;
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. The token enters cell 0 on the cycle after the accept
    // and drops off the far end once every cell has compared its key.
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd.start   = accept;
        cmd.ins     = commit && (op_reg == tot_pkg::OP_INSERT) && ok_next;
        cmd.upd     = commit && (op_reg == tot_pkg::OP_UPDATE) && ok_next;
        cmd.dlt     = commit && (op_reg == tot_pkg::OP_DELETE) && ok_next;
        cmd.key_col = key_col_reg;
        cmd.key_row = key_row_reg;
        cmd.tile    = tile_reg;
    end

    assign token[0] = accept && (req.operation != tot_pkg::OP_CLEAR);
    assign after[0] = 1'b0;

    for (genvar i = 0; i < Cap; i++)
    begin : g_cell
        logic [tot_pkg::COORD_W-1:0]  nb_col;
        logic [tot_pkg::COORD_W-1:0]  nb_row;
        logic [tot_pkg::TILE_W-1:0]   nb_tile;

        // The last cell has no neighbor; what it takes on a delete lies
        // at or beyond the new count and is never looked at again.
        if (i == Cap - 1)
        begin : g_last
            assign nb_col  = cell_col[i];
            assign nb_row  = cell_row[i];
            assign nb_tile = cell_tile[i];
        end
        else
        begin : g_mid
            assign nb_col  = cell_col[i+1];
            assign nb_row  = cell_row[i+1];
            assign nb_tile = cell_tile[i+1];
        end

        tot_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .token_in  (token[i]),
            .live      (CntW'(i) < count_reg),
            .ins_here  (CntW'(i) == count_reg),
            .after_in  (after[i]),
            .nb_col    (nb_col),
            .nb_row    (nb_row),
            .nb_tile   (nb_tile),
            .token_out (token[i+1]),
            .after_out (after[i+1]),
            .sel       (sel[i]),
            .col       (cell_col[i]),
            .row       (cell_row[i]),
            .tile      (cell_tile[i])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.operation == tot_pkg::OP_CLEAR) ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (token[Cap])
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Result. The view test uses nine-bit sums so the right and bottom
    // edges never wrap. A clear reloads the view clipped to the map.
    // ------------------------------------------------------------------
    assign view_x_end = {1'b0, view_x_reg} + SumW'(view_w_reg);
    assign view_y_end = {1'b0, view_y_reg} + SumW'(view_h_reg);

    assign visible = map_shown_reg &&
                     key_col_reg >= view_x_reg && {1'b0, key_col_reg} < view_x_end &&
                     key_row_reg >= view_y_reg && {1'b0, key_row_reg} < view_y_end;

    assign reload_on = map_shown_reg && view_x_reg < map_w_reg && view_y_reg < map_h_reg;
    assign clip_w    = map_w_reg - view_x_reg;
    assign clip_h    = map_h_reg - view_y_reg;

    always_comb
    begin
        ok_next    = 1'b0;
        kind_next  = tot_pkg::KIND_NONE;
        rx_next    = '0;
        ry_next    = '0;
        rw_next    = '0;
        rh_next    = '0;
        rt_next    = '0;
        count_next = count_reg;
        case (op_reg)
            tot_pkg::OP_INSERT:
            begin
                ok_next = !found && (count_reg < CntW'(Cap));
                if (ok_next)
                begin
                    count_next = count_reg + CntW'(1);
                end
            end
            tot_pkg::OP_UPDATE:
            begin
                ok_next = found;
            end
            tot_pkg::OP_DELETE:
            begin
                ok_next = found;
                if (ok_next)
                begin
                    count_next = count_reg - CntW'(1);
                end
            end
            default:
            begin
                ok_next    = 1'b1;
                count_next = '0;
            end
        endcase

        if (ok_next)
        begin
            if ((op_reg == tot_pkg::OP_INSERT || op_reg == tot_pkg::OP_UPDATE) && visible)
            begin
                kind_next = tot_pkg::KIND_DRAW;
                rx_next   = key_col_reg & tot_pkg::DRAW_MASK;
                ry_next   = key_row_reg & tot_pkg::DRAW_MASK;
                rw_next   = tot_pkg::SIZE_W'(1);
                rh_next   = tot_pkg::SIZE_W'(1);
                rt_next   = tile_reg;
            end
            else if (op_reg == tot_pkg::OP_DELETE && visible)
            begin
                kind_next = tot_pkg::KIND_RESTORE;
                rx_next   = key_col_reg;
                ry_next   = key_row_reg;
                rw_next   = tot_pkg::SIZE_W'(1);
                rh_next   = tot_pkg::SIZE_W'(1);
            end
            else if (op_reg == tot_pkg::OP_CLEAR && reload_on)
            begin
                kind_next = tot_pkg::KIND_RELOAD;
                rx_next   = view_x_reg;
                ry_next   = view_y_reg;
                rw_next   = (view_x_end > {1'b0, map_w_reg}) ? clip_w[tot_pkg::SIZE_W-1:0]
                                                             : view_w_reg;
                rh_next   = (view_y_end > {1'b0, map_h_reg}) ? clip_h[tot_pkg::SIZE_W-1:0]
                                                             : view_h_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= req.operation;
            key_col_reg <= req.cell_x;
            key_row_reg <= req.cell_y;
            tile_reg    <= req.tile_value;
        end
        if (commit)
        begin
            ok_reg   <= ok_next;
            kind_reg <= kind_next;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            rw_reg   <= rw_next;
            rh_reg   <= rh_next;
            rt_reg   <= rt_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.succeeded     = ok_reg;
    assign rsp.redraw_kind   = kind_reg;
    assign rsp.redraw_x      = rx_reg;
    assign rsp.redraw_y      = ry_reg;
    assign rsp.redraw_width  = rw_reg;
    assign rsp.redraw_height = rh_reg;
    assign rsp.redraw_tile   = rt_reg;

`ifndef ASSERT_OFF
    // Keys are unique, so a search never marks more than one cell.
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(sel))
        else $error("more than one cell matched the key");

    // Only one search token is ever in the chain.
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(token[Cap:1]))
        else $error("more than one search token in the chain");

    // The entry count stays within the table.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Cap))
        else $error("entry count beyond capacity");

    // A failed request never asks for a redraw.
    a_fail_no_redraw: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.succeeded) |-> (rsp.redraw_kind == tot_pkg::KIND_NONE))
        else $error("redraw requested for a failed request");

    // A commit always hands over a result on the next cycle.
    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("commit did not load the result register");
`endif

endmodule
